[rtl/core/tld_pkg.sv]
`timescale 1ns / 1ps
package tld_pkg;

   localparam int LINE_DEPTH = 32;
   localparam int IDX_W = $clog2(LINE_DEPTH);
   localparam int LEN_W = $clog2(LINE_DEPTH + 1);

   localparam logic [7:0] ESC_BYTE = 8'h1B;
   localparam logic [7:0] BS_BYTE = 8'h08;
   localparam logic [7:0] NL_BYTE = 8'h0A;
   localparam logic [7:0] SPACE_BYTE = 8'h20;
   localparam logic [7:0] CTRL_MASK = 8'h1F;

   localparam logic [2:0] KIND_CHAR = 3'd0;
   localparam logic [2:0] KIND_UP = 3'd1;
   localparam logic [2:0] KIND_DOWN = 3'd2;
   localparam logic [2:0] KIND_LEFT = 3'd3;
   localparam logic [2:0] KIND_RIGHT = 3'd4;
   localparam logic [2:0] KIND_DELETE = 3'd5;
   localparam logic [2:0] KIND_HOME = 3'd6;
   localparam logic [2:0] KIND_END = 3'd7;

   localparam logic REG_CANONICAL = 1'b0;
   localparam logic REG_ECHO = 1'b1;

   localparam logic DEST_READER = 1'b0;
   localparam logic DEST_ECHO = 1'b1;

   typedef enum logic [1:0] {
      SRC_SEQ   = 2'd0,
      SRC_LINE  = 2'd1,
      SRC_TAIL  = 2'd2,
      SRC_ERASE = 2'd3
   } src_type;

   typedef struct packed {
      logic    latch;
      logic    idx_clear;
      logic    idx_inc;
      logic    store;
      logic    len_dec;
      logic    len_clear;
      logic    emit;
      logic    dest;
      logic    last;
      src_type src;
   } cmd_type;

   typedef struct packed {
      logic release_key;
      logic canonical;
      logic echo;
      logic kind_zero;
      logic ch_zero;
      logic is_bs;
      logic is_nl;
      logic ctrl;
      logic len_zero;
      logic full;
      logic out_free;
      logic follow_echo;
      logic seq_done;
      logic erase_done;
      logic line_done;
   } status_type;

   function automatic logic [7:0] seq_byte(input logic [2:0] kind, input logic [1:0] pos);
      logic [7:0] code;
      case (kind)
         KIND_UP:     code = "A";
         KIND_DOWN:   code = "B";
         KIND_LEFT:   code = "D";
         KIND_RIGHT:  code = "C";
         KIND_DELETE: code = "3";
         KIND_HOME:   code = "H";
         KIND_END:    code = "F";
         default:     code = 8'h00;
      endcase
      case (pos)
         2'd0:    seq_byte = ESC_BYTE;
         2'd1:    seq_byte = "[";
         2'd2:    seq_byte = code;
         default: seq_byte = "~";
      endcase
   endfunction

   function automatic logic [1:0] seq_last(input logic [2:0] kind);
      if (kind == KIND_DELETE) begin
         seq_last = 2'd3;
      end else begin
         seq_last = 2'd2;
      end
   endfunction

endpackage

[rtl/core/tld_csr.sv]
`timescale 1ns / 1ps
module tld_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic        canonical,
   output logic        echo
);
   import tld_pkg::*;

   logic canonical_ff;
   logic canonical_in;
   logic echo_ff;
   logic echo_in;
   logic wr_en;

   assign wr_en = psel & penable & pwrite;

   always_comb begin
      canonical_in = canonical_ff;
      echo_in = echo_ff;
      if (wr_en && paddr[2] == REG_CANONICAL) begin
         canonical_in = pwdata[0];
      end
      if (wr_en && paddr[2] == REG_ECHO) begin
         echo_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         canonical_ff <= 1'b1;
         echo_ff <= 1'b1;
      end else begin
         canonical_ff <= canonical_in;
         echo_ff <= echo_in;
      end
   end

   assign prdata = {31'd0, (paddr[2] == REG_ECHO) ? echo_ff : canonical_ff};
   assign pready = 1'b1;
   assign canonical = canonical_ff;
   assign echo = echo_ff;
endmodule

[rtl/core/tld_datapath.sv]
`timescale 1ns / 1ps
module tld_datapath (
   input  logic                clock,
   input  logic                reset,
   input  logic                canonical,
   input  logic                echo,
   input  logic [2:0]          req_key_kind,
   input  logic [7:0]          req_char_code,
   input  logic                req_ctrl_held,
   input  logic                req_is_release,
   input  tld_pkg::cmd_type    cmd,
   output tld_pkg::status_type stat,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_destination,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_last_of_run
);
   import tld_pkg::*;

   logic [2:0]       kind_ff;
   logic [7:0]       ch_ff;
   logic             ctrl_ff;
   logic             release_ff;
   logic [LEN_W-1:0] idx_ff;
   logic [LEN_W-1:0] idx_in;
   logic [LEN_W-1:0] len_ff;
   logic [LEN_W-1:0] len_in;
   logic [7:0]       line_mem [LINE_DEPTH];
   logic [7:0]       rd_data_ff;
   logic             out_valid_ff;
   logic             out_valid_in;
   logic             out_dest_ff;
   logic [7:0]       out_byte_ff;
   logic             out_last_ff;
   logic [7:0]       tail_byte;
   logic [7:0]       seq_val;
   logic [7:0]       store_byte;
   logic [7:0]       emit_byte;
   logic             full;
   logic             do_store;

   assign full = (len_ff >= LEN_W'(LINE_DEPTH));
   assign do_store = cmd.store & ~full;
   assign seq_val = seq_byte(kind_ff, idx_ff[1:0]);

   always_comb begin
      if (ch_ff == NL_BYTE) begin
         tail_byte = NL_BYTE;
      end else if (ctrl_ff) begin
         tail_byte = ch_ff & CTRL_MASK;
      end else begin
         tail_byte = ch_ff;
      end
   end

   assign store_byte = (cmd.src == SRC_SEQ) ? seq_val : tail_byte;

   always_comb begin
      case (cmd.src)
         SRC_SEQ:   emit_byte = seq_val;
         SRC_LINE:  emit_byte = rd_data_ff;
         SRC_TAIL:  emit_byte = tail_byte;
         SRC_ERASE: emit_byte = (idx_ff[1:0] == 2'd1) ? SPACE_BYTE : BS_BYTE;
         default:   emit_byte = tail_byte;
      endcase
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_comb begin
      len_in = len_ff;
      if (cmd.len_clear) begin
         len_in = '0;
      end else if (cmd.len_dec) begin
         len_in = len_ff - 1'b1;
      end else if (do_store) begin
         len_in = len_ff + 1'b1;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         len_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         len_ff <= len_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         kind_ff <= req_key_kind;
         ch_ff <= req_char_code;
         ctrl_ff <= req_ctrl_held;
         release_ff <= req_is_release;
      end
      if (cmd.emit) begin
         out_dest_ff <= cmd.dest;
         out_byte_ff <= emit_byte;
         out_last_ff <= cmd.last;
      end
   end

   // The read address follows the next index so the read data always matches idx_ff.
   always_ff @(posedge clock) begin
      if (do_store) begin
         line_mem[len_ff[IDX_W-1:0]] <= store_byte;
      end
      rd_data_ff <= line_mem[idx_in[IDX_W-1:0]];
   end

   always_comb begin
      stat.release_key = release_ff;
      stat.canonical = canonical;
      stat.echo = echo;
      stat.kind_zero = (kind_ff == KIND_CHAR);
      stat.ch_zero = (ch_ff == 8'h00);
      stat.is_bs = (ch_ff == BS_BYTE);
      stat.is_nl = (ch_ff == NL_BYTE);
      stat.ctrl = ctrl_ff;
      stat.len_zero = (len_ff == '0);
      stat.full = full;
      stat.out_free = ~out_valid_ff | rsp_ready;
      stat.follow_echo = echo & (canonical ? (ch_ff == NL_BYTE) : ~ctrl_ff);
      stat.seq_done = (idx_ff[1:0] == seq_last(kind_ff));
      stat.erase_done = (idx_ff[1:0] == 2'd2);
      stat.line_done = ((idx_ff + 1'b1) == len_ff);
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_destination = out_dest_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_last_of_run = out_last_ff;
endmodule

[rtl/core/tld_ctrl.sv]
`timescale 1ns / 1ps
module tld_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  tld_pkg::status_type stat,
   output tld_pkg::cmd_type    cmd
);
   import tld_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_DECODE = 7'b0000010,
      ST_SEQ    = 7'b0000100,
      ST_ERASE  = 7'b0001000,
      ST_LINE   = 7'b0010000,
      ST_READER = 7'b0100000,
      ST_ECHO   = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.src = SRC_TAIL;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               cmd.idx_clear = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_IDLE;
            if (stat.release_key) begin
               state_in = ST_IDLE;
            end else if (!stat.kind_zero) begin
               state_in = ST_SEQ;
            end else if (stat.ch_zero) begin
               state_in = ST_IDLE;
            end else if (!stat.canonical) begin
               state_in = ST_READER;
            end else if (stat.is_bs) begin
               if (!stat.len_zero) begin
                  cmd.len_dec = 1'b1;
                  if (stat.echo) begin
                     state_in = ST_ERASE;
                  end
               end
            end else if (stat.is_nl) begin
               state_in = stat.len_zero ? ST_READER : ST_LINE;
            end else begin
               cmd.store = 1'b1;
               if (!stat.ctrl && !stat.full && stat.echo) begin
                  state_in = ST_ECHO;
               end
            end
         end
         ST_SEQ: begin
            cmd.src = SRC_SEQ;
            if (stat.canonical) begin
               cmd.store = 1'b1;
               cmd.idx_inc = 1'b1;
               if (stat.seq_done) begin
                  state_in = ST_IDLE;
               end
            end else if (stat.out_free) begin
               cmd.emit = 1'b1;
               cmd.dest = DEST_READER;
               cmd.last = stat.seq_done;
               cmd.idx_inc = 1'b1;
               if (stat.seq_done) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_ERASE: begin
            cmd.src = SRC_ERASE;
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               cmd.dest = DEST_ECHO;
               cmd.last = stat.erase_done;
               cmd.idx_inc = 1'b1;
               if (stat.erase_done) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_LINE: begin
            cmd.src = SRC_LINE;
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               cmd.dest = DEST_READER;
               cmd.idx_inc = 1'b1;
               if (stat.line_done) begin
                  cmd.len_clear = 1'b1;
                  state_in = ST_READER;
               end
            end
         end
         ST_READER: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               cmd.dest = DEST_READER;
               cmd.last = ~stat.follow_echo;
               state_in = stat.follow_echo ? ST_ECHO : ST_IDLE;
            end
         end
         ST_ECHO: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               cmd.dest = DEST_ECHO;
               cmd.last = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
endmodule

[rtl/core/terminal_line_discipline_unit.sv]
`timescale 1ns / 1ps
// Terminal line discipline. Key events enter on the req_ channel and bytes leave on the
// rsp_ channel, each tagged for the reader queue or for the screen echo, with
// rsp_last_of_run marking the final byte that one request causes.
// The block works on one request at a time: req_ready is high only while it is idle.
// A request is taken in ST_IDLE and then decoded in ST_DECODE; a release or a
// request with no bytes is then done. Result bytes leave one per cycle while the
// receiver keeps rsp_ready high. A newline with echo on a full line of 32 bytes
// yields 34 bytes, and an escape key in canonical mode only adds its sequence to
// the line and emits nothing.
// The single-entry output register limits the rate to one byte per cycle.
// When the receiver stalls, the output register holds its byte and the sequencer waits.
// Reset sets canonical mode and echo, empties the line and drops any pending result.
// The APB-style port holds canonical_mode at address 0 and echo_enable at address 4;
// it should be written only while the block is idle.
module terminal_line_discipline_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_key_kind,
   input  logic [7:0]  req_char_code,
   input  logic        req_ctrl_held,
   input  logic        req_is_release,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_destination,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_of_run,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import tld_pkg::*;

   logic       canonical;
   logic       echo;
   cmd_type    ctl_cmd;
   status_type stat;

   tld_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .canonical (canonical),
      .echo      (echo)
   );

   tld_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (ctl_cmd)
   );

   tld_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .canonical       (canonical),
      .echo            (echo),
      .req_key_kind    (req_key_kind),
      .req_char_code   (req_char_code),
      .req_ctrl_held   (req_ctrl_held),
      .req_is_release  (req_is_release),
      .cmd             (ctl_cmd),
      .stat            (stat),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_destination (rsp_destination),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

`ifndef ASSERT_OFF
   a_emit_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.emit |-> stat.out_free)
      else $error("A result was loaded while the output register was still occupied.");

   a_one_request_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("A second request was taken before the first was decoded.");

   a_no_erase_on_empty_line: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.len_dec |-> !stat.len_zero)
      else $error("A backspace shortened an empty line.");
`endif
endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
   import tld_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES = 50;
   localparam int HOLD_CYCLES = 400;
   localparam int HOLD_AFTER = 250;
   localparam int PHASE_ITEMS = 67;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] ch;
      logic       ctrl;
      logic       rel;
   } key_event_type;

   typedef struct packed {
      logic       dest;
      logic [7:0] data;
      logic       last;
   } tty_byte_type;

   class tty_scoreboard_type;
      bit           canonical;
      bit           echo;
      logic [7:0]   line_buf[LINE_DEPTH];
      int unsigned  line_len;
      tty_byte_type expected_q[$];
      int unsigned  error_count;
      int unsigned  checked_count;

      function new();
         canonical = 1'b1;
         echo = 1'b1;
         line_len = 0;
         error_count = 0;
         checked_count = 0;
      endfunction

      function void set_reg(logic idx, bit val);
         if (idx == REG_CANONICAL) begin
            canonical = val;
         end else begin
            echo = val;
         end
      endfunction

      function void push(logic dest, logic [7:0] data);
         tty_byte_type item;
         item = '{dest: dest, data: data, last: 1'b0};
         expected_q.insert(expected_q.size(), item);
      endfunction

      function bit append(logic [7:0] data);
         if (line_len >= LINE_DEPTH) begin
            return 1'b0;
         end
         line_buf[line_len] = data;
         line_len++;
         return 1'b1;
      endfunction

      function void note_key(key_event_type k);
         int         first;
         int         seq_n;
         logic [7:0] seq[4];
         logic [7:0] letter;
         first = expected_q.size();
         seq_n = 0;
         if (k.rel) begin
            return;
         end
         if (k.kind != KIND_CHAR) begin
            case (k.kind)
               KIND_UP:    letter = "A";
               KIND_DOWN:  letter = "B";
               KIND_LEFT:  letter = "D";
               KIND_RIGHT: letter = "C";
               KIND_HOME:  letter = "H";
               KIND_END:   letter = "F";
               default:    letter = "3";
            endcase
            seq[0] = ESC_BYTE;
            seq[1] = "[";
            seq[2] = letter;
            seq[3] = "~";
            seq_n = (k.kind == KIND_DELETE) ? 4 : 3;
         end
         if (canonical) begin
            if (k.kind != KIND_CHAR) begin
               for (int i = 0; i < seq_n; i++) begin
                  void'(append(seq[i]));
               end
            end else if (k.ch == 8'h00) begin
            end else if (k.ch == BS_BYTE) begin
               if (line_len > 0) begin
                  line_len--;
                  if (echo) begin
                     push(DEST_ECHO, BS_BYTE);
                     push(DEST_ECHO, SPACE_BYTE);
                     push(DEST_ECHO, BS_BYTE);
                  end
               end
            end else if (k.ch == NL_BYTE) begin
               for (int i = 0; i < line_len; i++) begin
                  push(DEST_READER, line_buf[i]);
               end
               push(DEST_READER, NL_BYTE);
               line_len = 0;
               if (echo) begin
                  push(DEST_ECHO, NL_BYTE);
               end
            end else if (k.ctrl) begin
               void'(append(k.ch & CTRL_MASK));
            end else if (append(k.ch) && echo) begin
               push(DEST_ECHO, k.ch);
            end
         end else begin
            if (k.kind != KIND_CHAR) begin
               for (int i = 0; i < seq_n; i++) begin
                  push(DEST_READER, seq[i]);
               end
            end else if (k.ch != 8'h00) begin
               if (k.ctrl) begin
                  push(DEST_READER, k.ch & CTRL_MASK);
               end else begin
                  push(DEST_READER, k.ch);
                  if (echo) begin
                     push(DEST_ECHO, k.ch);
                  end
               end
            end
         end
         if (expected_q.size() > first) begin
            expected_q[$].last = 1'b1;
         end
      endfunction

      function void check_byte(tty_byte_type got);
         tty_byte_type want;
         if (expected_q.size() == 0) begin
            $error("unexpected result: dest %0d byte %02h last %0d",
                   got.dest, got.data, got.last);
            error_count++;
            return;
         end
         want = expected_q.pop_front();
         checked_count++;
         if (got.dest !== want.dest) begin
            $error("destination: expected %0d, actual %0d", want.dest, got.dest);
            error_count++;
         end
         if (got.data !== want.data) begin
            $error("out_byte: expected %02h, actual %02h", want.data, got.data);
            error_count++;
         end
         if (got.last !== want.last) begin
            $error("last_of_run: expected %0d, actual %0d", want.last, got.last);
            error_count++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_key_kind = KIND_CHAR;
   logic [7:0]  req_char_code = 8'h00;
   logic        req_ctrl_held = 1'b0;
   logic        req_is_release = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_destination;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last_of_run;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = 3'd0;
   logic [31:0] pwdata = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   tty_scoreboard_type sb = new();
   int          send_idle_pct = 8;
   int          recv_idle_pct = 69;
   int          stall_cycles = 0;
   int unsigned typed_count = 0;
   int unsigned line_goal = 5;

   terminal_line_discipline_unit u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_key_kind(req_key_kind),
      .req_char_code(req_char_code),
      .req_ctrl_held(req_ctrl_held),
      .req_is_release(req_is_release),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_destination(rsp_destination),
      .rsp_out_byte(rsp_out_byte),
      .rsp_last_of_run(rsp_last_of_run),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic send_key(key_event_type k);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_key_kind <= k.kind;
      req_char_code <= k.ch;
      req_ctrl_held <= k.ctrl;
      req_is_release <= k.rel;
      do @(posedge clock); while (!req_ready);
      sb.note_key(k);
   endtask

   task automatic key(logic [2:0] kind, logic [7:0] ch, logic ctrl, logic rel);
      send_key('{kind: kind, ch: ch, ctrl: ctrl, rel: rel});
   endtask

   task automatic write_csr(logic idx, bit val);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= {31'($urandom()), val};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.set_reg(idx, val);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // Registers may only change while the block is idle, so wait for every
   // outstanding byte and give a request with no output time to finish.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(bit canonical, bit echo);
      drain();
      write_csr(REG_CANONICAL, canonical);
      write_csr(REG_ECHO, echo);
   endtask

   // Mostly typed lines of printable text closed by a newline, mixed with
   // edits, escape keys, control bytes and some noise.
   function automatic key_event_type random_key();
      key_event_type k;
      int            r;
      r = $urandom_range(0, 99);
      k = '{kind: KIND_CHAR, ch: 8'h00, ctrl: 1'b0, rel: 1'b0};
      if ((typed_count >= line_goal && r < 80) || (r >= 86 && r < 92)) begin
         k.ch = NL_BYTE;
         k.ctrl = 1'($urandom_range(0, 1));
         typed_count = 0;
         line_goal = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 45)
                                                 : $urandom_range(1, 12);
      end else if (r < 50) begin
         k.ch = 8'($urandom_range(8'h20, 8'h7E));
         typed_count++;
      end else if (r < 60) begin
         k.ch = BS_BYTE;
         k.ctrl = 1'($urandom_range(0, 1));
      end else if (r < 70) begin
         k.kind = 3'($urandom_range(KIND_UP, KIND_END));
         k.ch = 8'($urandom_range(0, 255));
         k.ctrl = 1'($urandom_range(0, 1));
      end else if (r < 78) begin
         k.ch = 8'($urandom_range(1, 255));
         k.ctrl = 1'b1;
      end else if (r < 86) begin
         k.ch = 8'($urandom_range(0, 255));
         k.ctrl = 1'($urandom_range(0, 1));
      end else if (r < 96) begin
         k.kind = 3'($urandom_range(0, 7));
         k.ch = 8'($urandom_range(0, 255));
         k.ctrl = 1'($urandom_range(0, 1));
         k.rel = 1'b1;
      end else begin
         k.ctrl = 1'($urandom_range(0, 1));
      end
      return k;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_byte('{dest: rsp_destination, data: rsp_out_byte, last: rsp_last_of_run});
      end
   end

   initial begin
      int  hold_left;
      bit  hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (!hold_done && sb.checked_count >= HOLD_AFTER) begin
            rsp_ready <= 1'b0;
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (psel && penable && pwrite && pready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("terminal_line_discipline_unit: mismatch");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      bit            canon_cfg[6] = '{1, 0, 1, 0, 1, 1};
      bit            echo_cfg[6] = '{1, 0, 0, 1, 1, 0};
      int            sent;
      key_event_type k;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Canonical mode with echo, as after reset.
      key(KIND_CHAR, "a", 1'b0, 1'b1);
      key(KIND_CHAR, 8'h00, 1'b0, 1'b0);
      key(KIND_CHAR, "a", 1'b0, 1'b0);
      key(KIND_CHAR, 8'hFF, 1'b0, 1'b0);
      key(KIND_CHAR, "c", 1'b1, 1'b0);
      key(KIND_CHAR, BS_BYTE, 1'b1, 1'b0);
      key(KIND_CHAR, BS_BYTE, 1'b0, 1'b0);
      for (int kd = KIND_UP; kd <= KIND_END; kd++) begin
         key(3'(kd), 8'hFF, kd[0], 1'b0);
      end
      key(KIND_DELETE, 8'h00, 1'b0, 1'b0);
      key(KIND_DELETE, 8'h00, 1'b0, 1'b0);
      // The line is now one byte short of full.
      key(KIND_CHAR, "x", 1'b0, 1'b0);
      key(KIND_CHAR, "y", 1'b0, 1'b0);
      key(KIND_HOME, 8'h00, 1'b0, 1'b0);
      key(KIND_CHAR, NL_BYTE, 1'b1, 1'b0);
      key(KIND_CHAR, BS_BYTE, 1'b0, 1'b0);

      configure(1'b0, 1'b1);
      key(KIND_CHAR, "a", 1'b0, 1'b0);
      key(KIND_CHAR, "a", 1'b1, 1'b0);
      key(KIND_CHAR, BS_BYTE, 1'b0, 1'b0);
      key(KIND_CHAR, NL_BYTE, 1'b0, 1'b0);
      key(KIND_DELETE, 8'h00, 1'b0, 1'b0);
      key(KIND_CHAR, 8'h00, 1'b0, 1'b0);

      for (int phase = 0; phase < 6; phase++) begin
         configure(canon_cfg[phase], echo_cfg[phase]);
         send_idle_pct = (phase < 2) ? 8 : (phase < 4) ? 69 : 0;
         recv_idle_pct = (phase < 2) ? 69 : (phase < 4) ? 8 : 0;
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            k = random_key();
            send_key(k);
            sent++;
         end
      end

      drain();
      if (sb.error_count == 0) begin
         $display("terminal_line_discipline_unit: match");
      end else begin
         $display("terminal_line_discipline_unit: mismatch");
      end
      $finish;
   end

endmodule
